// File: hdl/rspm_pkg.sv
// Shared constants, op codes, sequencer states and table write port type for the route matcher.
package rspm_pkg;

    // Table geometry
    localparam int MAX_ROUTES        = 64;
    localparam int MAX_ROUTE_BUTTONS = 8;
    localparam int BUTTON_ID_BITS    = 8;

    localparam int ROUTE_W = $clog2(MAX_ROUTES);
    localparam int POS_W   = $clog2(MAX_ROUTE_BUTTONS);
    localparam int SCAN_W  = ROUTE_W + 1;
    localparam int CNT_W   = $clog2(MAX_ROUTE_BUTTONS + 1);
    localparam int LEN_W   = 4;
    localparam int OP_W    = 3;
    localparam int CFG_W   = 7;

    // Item op codes
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_PRESS   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd3;
    localparam logic [OP_W-1:0] OP_FAULT   = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Route table write port
    typedef struct packed {
        logic                      en;
        logic [ROUTE_W-1:0]        route;
        logic [POS_W-1:0]          pos;
        logic [BUTTON_ID_BITS-1:0] button;
        logic [LEN_W-1:0]          length;
    } tbl_wr_t;

endpackage

// File: hdl/rspm_route_table.sv
// Route button and route length memories with one write port and a registered read port.
module rspm_route_table
(
    input  logic                                clk,
    input  rspm_pkg::tbl_wr_t                   wr,
    input  logic [rspm_pkg::ROUTE_W-1:0]        rd_route,
    input  logic [rspm_pkg::POS_W-1:0]          rd_pos,
    output logic [rspm_pkg::BUTTON_ID_BITS-1:0] rd_button,
    output logic [rspm_pkg::LEN_W-1:0]          rd_length
);

    logic [rspm_pkg::BUTTON_ID_BITS-1:0] button_mem
        [rspm_pkg::MAX_ROUTES * rspm_pkg::MAX_ROUTE_BUTTONS];
    logic [rspm_pkg::LEN_W-1:0]          length_mem [rspm_pkg::MAX_ROUTES];

    logic [rspm_pkg::BUTTON_ID_BITS-1:0] rd_button_reg;
    logic [rspm_pkg::LEN_W-1:0]          rd_length_reg;

    // Write one sequence entry and the route length, read the addressed pair
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            button_mem[{wr.route, wr.pos}] <= wr.button;
            length_mem[wr.route]           <= wr.length;
        end
        rd_button_reg <= button_mem[{rd_route, rd_pos}];
        rd_length_reg <= length_mem[rd_route];
    end

    assign rd_button = rd_button_reg;
    assign rd_length = rd_length_reg;

endmodule

// File: hdl/route_selection_prefix_matcher.sv
// Route selection group: press sequencer with one shared route comparator and result register.
//
//  channel   handshake              payload
//  item      item_valid/item_stall  op, button, route_index, position, route_length,
//                                   built_route_held
//  result    result_valid/result_stall
//                                   accepted, build_request, build_route,
//                                   clear_indications, selection_in_progress
//  config    cfg_valid/cfg_ready    cfg_data (routes_in_use)
//
// A press walks all 64 routes through one comparator, one route a cycle, behind the
// registered table read; other ops, and a first press with a built route held, skip it.
// The block takes one item at a time; item_stall is high from acceptance until the
// result is written into the output register, which holds it while result_stall is high.
// Reset clears the selection state and routes_in_use; the route table is not cleared.
module route_selection_prefix_matcher
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [rspm_pkg::OP_W-1:0]           op,
    input  logic [rspm_pkg::BUTTON_ID_BITS-1:0] button,
    input  logic [rspm_pkg::ROUTE_W-1:0]        route_index,
    input  logic [rspm_pkg::POS_W-1:0]          position,
    input  logic [rspm_pkg::LEN_W-1:0]          route_length,
    input  logic                                built_route_held,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                accepted,
    output logic                                build_request,
    output logic [rspm_pkg::ROUTE_W-1:0]        build_route,
    output logic                                clear_indications,
    output logic                                selection_in_progress,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rspm_pkg::CFG_W-1:0]          cfg_data
);

    rspm_pkg::state_t state_reg, state_next;

    // Latched item
    logic [rspm_pkg::OP_W-1:0]           op_reg;
    logic [rspm_pkg::BUTTON_ID_BITS-1:0] btn_reg;
    logic [rspm_pkg::ROUTE_W-1:0]        ridx_reg;
    logic [rspm_pkg::POS_W-1:0]          posn_reg;
    logic [rspm_pkg::LEN_W-1:0]          rlen_reg;
    logic                                first_reg;

    // Scan sequencer
    logic [rspm_pkg::SCAN_W-1:0]     scan_reg;
    logic                            pend_reg;
    logic [rspm_pkg::ROUTE_W-1:0]    pend_idx_reg;
    logic [1:0]                      hits_reg;
    logic [rspm_pkg::ROUTE_W-1:0]    last_reg;
    logic [rspm_pkg::MAX_ROUTES-1:0] next_mask_reg;

    // Selection state
    logic [rspm_pkg::MAX_ROUTES-1:0]     mask_reg, mask_next;
    logic [rspm_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                                active_reg, active_next;
    logic [rspm_pkg::BUTTON_ID_BITS-1:0] btns_reg [rspm_pkg::MAX_ROUTE_BUTTONS];
    logic [rspm_pkg::CFG_W-1:0]          cfg_reg;

    // Result register
    logic                         res_valid_reg;
    logic                         res_acc_reg;
    logic                         res_req_reg;
    logic [rspm_pkg::ROUTE_W-1:0] res_route_reg;
    logic                         res_clr_reg;
    logic                         res_sel_reg;

    // Control and datapath signals
    logic                                accept;
    logic                                out_free;
    logic                                commit;
    logic                                scan_issue;
    logic                                first_now;
    logic [rspm_pkg::CNT_W-1:0]          scan_pos;
    logic                                cand;
    logic                                match;
    logic                                found;
    logic                                append_en;
    logic                                c_acc;
    logic                                c_req;
    logic [rspm_pkg::ROUTE_W-1:0]        c_route;
    logic                                c_clr;
    rspm_pkg::tbl_wr_t                   tbl_wr;
    logic [rspm_pkg::BUTTON_ID_BITS-1:0] rd_button;
    logic [rspm_pkg::LEN_W-1:0]          rd_length;

    // Route table
    rspm_route_table u_table
    (
        .clk       (clk),
        .wr        (tbl_wr),
        .rd_route  (scan_reg[rspm_pkg::ROUTE_W-1:0]),
        .rd_pos    (scan_pos[rspm_pkg::POS_W-1:0]),
        .rd_button (rd_button),
        .rd_length (rd_length)
    );

    assign first_now = (count_reg == '0) && !active_reg;
    assign scan_pos  = first_reg ? '0 : count_reg;

    // Sequencer outputs
    always_comb
    begin
        item_stall = (state_reg != rspm_pkg::ST_IDLE);
        accept     = item_valid && (state_reg == rspm_pkg::ST_IDLE);
        out_free   = !res_valid_reg || !result_stall;
        commit     = (state_reg == rspm_pkg::ST_DONE) && out_free;
        scan_issue = (state_reg == rspm_pkg::ST_SCAN)
                     && (scan_reg < rspm_pkg::SCAN_W'(rspm_pkg::MAX_ROUTES));
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rspm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == rspm_pkg::OP_PRESS && !(first_now && built_route_held))
                        state_next = rspm_pkg::ST_SCAN;
                    else
                        state_next = rspm_pkg::ST_DONE;
                end
            end
            rspm_pkg::ST_SCAN:
            begin
                if (!scan_issue && !pend_reg)
                    state_next = rspm_pkg::ST_DONE;
            end
            rspm_pkg::ST_DONE:
            begin
                if (commit)
                    state_next = rspm_pkg::ST_IDLE;
            end
            default:
                state_next = rspm_pkg::ST_IDLE;
        endcase
    end

    // Compare the route whose table data just arrived
    always_comb
    begin
        if (first_reg)
            cand = ({1'b0, pend_idx_reg} < cfg_reg);
        else
            cand = mask_reg[pend_idx_reg];
        match = cand
                && (scan_pos < rspm_pkg::CNT_W'(rspm_pkg::MAX_ROUTE_BUTTONS))
                && (scan_pos < rd_length)
                && (rd_button == btn_reg);
    end

    // Search the pressed list for a release
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < rspm_pkg::MAX_ROUTE_BUTTONS; i++)
        begin
            if ((rspm_pkg::CNT_W'(i) < count_reg) && (btns_reg[i] == btn_reg))
                found = 1'b1;
        end
    end

    // Result and selection update at commit
    always_comb
    begin
        mask_next   = mask_reg;
        count_next  = count_reg;
        active_next = active_reg;
        append_en   = 1'b0;
        c_acc       = 1'b0;
        c_req       = 1'b0;
        c_route     = '0;
        c_clr       = 1'b0;
        unique case (op_reg)
            rspm_pkg::OP_LOAD:
                c_acc = 1'b1;
            rspm_pkg::OP_PRESS:
            begin
                if (hits_reg != 2'd0)
                begin
                    c_acc     = 1'b1;
                    append_en = (count_reg < rspm_pkg::CNT_W'(rspm_pkg::MAX_ROUTE_BUTTONS));
                    mask_next = next_mask_reg;
                    if (append_en)
                        count_next = count_reg + 1'b1;
                    if (first_reg)
                        active_next = 1'b1;
                    else if (hits_reg == 2'd1)
                    begin
                        c_req      = 1'b1;
                        c_route    = last_reg;
                        mask_next  = '0;
                        count_next = '0;
                    end
                end
            end
            rspm_pkg::OP_RELEASE:
            begin
                if (found)
                begin
                    mask_next   = '0;
                    count_next  = '0;
                    active_next = 1'b0;
                    c_acc       = 1'b1;
                    c_clr       = 1'b1;
                end
            end
            rspm_pkg::OP_CANCEL:
            begin
                if (count_reg != '0 || active_reg)
                begin
                    mask_next   = '0;
                    count_next  = '0;
                    active_next = 1'b0;
                    c_acc       = 1'b1;
                    c_clr       = 1'b1;
                end
            end
            rspm_pkg::OP_FAULT:
            begin
                mask_next   = '0;
                count_next  = '0;
                active_next = 1'b0;
                c_clr       = 1'b1;
            end
            default:
            begin
                c_acc = 1'b0;
            end
        endcase
    end

    // Drive the table write for a load
    always_comb
    begin
        tbl_wr.en     = commit && (op_reg == rspm_pkg::OP_LOAD);
        tbl_wr.route  = ridx_reg;
        tbl_wr.pos    = posn_reg;
        tbl_wr.button = btn_reg;
        tbl_wr.length = rlen_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rspm_pkg::ST_IDLE;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            hits_reg      <= 2'd0;
            mask_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            cfg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take a configuration write
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;

            // Start or advance the route walk
            if (accept)
            begin
                scan_reg <= '0;
                pend_reg <= 1'b0;
                hits_reg <= 2'd0;
            end
            else if (state_reg == rspm_pkg::ST_SCAN)
            begin
                if (scan_issue)
                    scan_reg <= scan_reg + 1'b1;
                pend_reg <= scan_issue;
                if (pend_reg && match && hits_reg != 2'd2)
                    hits_reg <= hits_reg + 1'b1;
            end

            // Update the selection
            if (commit)
            begin
                mask_reg   <= mask_next;
                count_reg  <= count_next;
                active_reg <= active_next;
            end

            // Hold or drop the result
            if (commit)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            btn_reg   <= button;
            ridx_reg  <= route_index;
            posn_reg  <= position;
            rlen_reg  <= route_length;
            first_reg <= first_now;
            last_reg  <= '0;
        end
        if (state_reg == rspm_pkg::ST_SCAN)
        begin
            pend_idx_reg <= scan_reg[rspm_pkg::ROUTE_W-1:0];
            if (pend_reg)
            begin
                next_mask_reg[pend_idx_reg] <= match;
                if (match)
                    last_reg <= pend_idx_reg;
            end
        end
        if (commit && append_en)
            btns_reg[count_reg[rspm_pkg::POS_W-1:0]] <= btn_reg;
        if (commit)
        begin
            res_acc_reg   <= c_acc;
            res_req_reg   <= c_req;
            res_route_reg <= c_route;
            res_clr_reg   <= c_clr;
            res_sel_reg   <= active_next;
        end
    end

    assign cfg_ready             = 1'b1;
    assign result_valid          = res_valid_reg;
    assign accepted              = res_acc_reg;
    assign build_request         = res_req_reg;
    assign build_route           = res_route_reg;
    assign clear_indications     = res_clr_reg;
    assign selection_in_progress = res_sel_reg;

    // An idle selection holds no pressed buttons and no candidates
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (count_reg == '0 && mask_reg == '0))
        else $error("pressed list or candidates left without a selection");

    // A build request is an accepted press that keeps the selection flag set
    a_build_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_req_reg) |-> (res_acc_reg && !res_clr_reg && res_sel_reg))
        else $error("build request with inconsistent result flags");

    // The route walk never runs past the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rspm_pkg::ST_SCAN)
            |-> (scan_reg <= rspm_pkg::SCAN_W'(rspm_pkg::MAX_ROUTES)))
        else $error("route walk ran past the last route");

endmodule
